// ===== design/ufq_pkg.sv =====
// Shared types and constants for the unique queue with remove and find.
`default_nettype none
package ufq_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int HANDLE_W      = 16;
   localparam int ID_W          = 16;
   localparam int COUNT_OUT_W   = 5;

   typedef enum logic [1:0] {
      CMD_PUT    = 2'd0,
      CMD_GET    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_FIND   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_DONE = 2'd0,
      STAT_DUP  = 2'd1,
      STAT_MISS = 2'd2,
      STAT_FULL = 2'd3
   } status_type;

   // command held steady for the whole scan
   typedef struct packed {
      cmd_type             cmd;
      logic [HANDLE_W-1:0] handle;
      logic [ID_W-1:0]     key;
   } op_type;

   // token handed from cell to cell
   typedef struct packed {
      logic                active;
      logic                found;
      logic [HANDLE_W-1:0] handle;
   } pass_type;

   // state update issued at the end of a scan
   typedef struct packed {
      logic load;
      logic shift;
   } apply_type;

endpackage
`default_nettype wire

// ===== design/ufq_if.sv =====
// Valid/ready channel interfaces for command words and result words.
`default_nettype none
interface ufq_req_if;
   import ufq_pkg::*;
   logic                valid;
   logic                ready;
   cmd_type             cmd;
   logic [HANDLE_W-1:0] handle;
   logic [ID_W-1:0]     entry_id;

   modport source (output valid, output cmd, output handle, output entry_id, input ready);
   modport sink   (input valid, input cmd, input handle, input entry_id, output ready);
endinterface

interface ufq_rsp_if;
   import ufq_pkg::*;
   logic                   valid;
   logic                   ready;
   status_type             status;
   logic [HANDLE_W-1:0]    handle_out;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, output status, output handle_out, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input handle_out, input entry_count,
                   output ready);
endinterface
`default_nettype wire

// ===== design/ufq_cell.sv =====
// One queue slot: stores a handle and id, compares, and passes the scan token on.
`default_nettype none
module ufq_cell #(
   parameter int DEPTH = ufq_pkg::DEFAULT_DEPTH,
   parameter int INDEX = 0,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  ufq_pkg::op_type              op,
   input  ufq_pkg::apply_type           apply,
   input  wire  [CW-1:0]                count,
   input  ufq_pkg::pass_type            pass_prev,
   output ufq_pkg::pass_type            pass_next,
   input  wire  [ufq_pkg::HANDLE_W-1:0] nb_handle,
   input  wire  [ufq_pkg::ID_W-1:0]     nb_id,
   output logic [ufq_pkg::HANDLE_W-1:0] slot_handle,
   output logic [ufq_pkg::ID_W-1:0]     slot_id
);
   import ufq_pkg::*;

   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic                after_ff, after_in;
   pass_type            pass_ff, pass_in;
   logic                occupied;
   logic                hit;

   assign occupied = CW'(INDEX) < count;

   // get hits every occupied slot; the token keeps the first hit, slot 0, the oldest
   always_comb begin
      case (op.cmd)
         CMD_GET:  hit = occupied;
         CMD_FIND: hit = occupied && (id_ff == op.key);
         default:  hit = occupied && (handle_ff == op.handle);
      endcase
   end

   always_comb begin
      pass_in  = '0;
      after_in = after_ff;
      if (pass_prev.active) begin
         pass_in.active = 1'b1;
         pass_in.found  = pass_prev.found | hit;
         pass_in.handle = pass_prev.found ? pass_prev.handle : handle_ff;
         // at or behind the first hit: this slot closes the gap on removal
         after_in       = pass_prev.found | hit;
      end
   end

   always_comb begin
      handle_in = handle_ff;
      id_in     = id_ff;
      if (apply.load && (CW'(INDEX) == count)) begin
         handle_in = op.handle;
         id_in     = op.key;
      end else if (apply.shift && after_ff) begin
         handle_in = nb_handle;
         id_in     = nb_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= '0;
      end else begin
         pass_ff <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      id_ff     <= id_in;
      after_ff  <= after_in;
   end

   assign pass_next   = pass_ff;
   assign slot_handle = handle_ff;
   assign slot_id     = id_ff;

endmodule
`default_nettype wire

// ===== design/ufq_ctrl.sv =====
// Command sequencer: takes a word, launches the scan, settles status and count.
`default_nettype none
module ufq_ctrl #(
   parameter int DEPTH = ufq_pkg::DEFAULT_DEPTH,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  wire                clock,
   input  wire                reset,
   ufq_req_if.sink            req_bus,
   ufq_rsp_if.source          rsp_bus,
   output ufq_pkg::op_type    op,
   output ufq_pkg::pass_type  chain_start,
   input  ufq_pkg::pass_type  chain_end,
   output ufq_pkg::apply_type apply,
   output logic [CW-1:0]      count
);
   import ufq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic                start_ff, start_in;
   logic [CW-1:0]       count_ff, count_in;
   status_type          status_ff, status_in;
   logic [HANDLE_W-1:0] hout_ff, hout_in;
   logic                full;

   assign full = count_ff == CW'(DEPTH);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      start_in  = 1'b0;
      count_in  = count_ff;
      status_in = status_ff;
      hout_in   = hout_ff;
      apply     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in.cmd    = req_bus.cmd;
               op_in.handle = req_bus.handle;
               op_in.key    = req_bus.entry_id;
               start_in     = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (chain_end.active) begin
               state_in  = S_RESP;
               status_in = STAT_DONE;
               hout_in   = '0;
               case (op_ff.cmd)
                  CMD_PUT: begin
                     if (chain_end.found) begin
                        status_in = STAT_DUP;
                     end else if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        apply.load = 1'b1;
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  CMD_FIND: begin
                     if (chain_end.found) begin
                        hout_in = chain_end.handle;
                     end else begin
                        status_in = STAT_MISS;
                     end
                  end
                  default: begin
                     // get and remove both pull the younger slots forward
                     if (chain_end.found) begin
                        apply.shift = 1'b1;
                        count_in    = count_ff - CW'(1);
                        if (op_ff.cmd == CMD_GET) begin
                           hout_in = chain_end.handle;
                        end
                     end else begin
                        status_in = STAT_MISS;
                     end
                  end
               endcase
            end
         end
         S_RESP: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
      hout_ff   <= hout_in;
   end

   assign req_bus.ready       = state_ff == S_IDLE;
   assign rsp_bus.valid       = state_ff == S_RESP;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.handle_out  = hout_ff;
   assign rsp_bus.entry_count = COUNT_OUT_W'(count_ff);

   assign op                 = op_ff;
   assign chain_start.active = start_ff;
   assign chain_start.found  = 1'b0;
   assign chain_start.handle = '0;
   assign count              = count_ff;

endmodule
`default_nettype wire

// ===== design/unique_fifo_with_remove_and_find_core.sv =====
// Top level of the ordered unique handle queue with remove and find.
//
// Ordered queue of task handles, each stored with a 16-bit task id, built as a
// row of DEPTH slot cells with slot 0 always the oldest. Every command word
// (put, get, remove, find) returns exactly one result word: status, the popped
// or found handle, and the entry count after the command (low five bits). Put
// drops a handle that is already queued (duplicate) before checking for full.
// Rate: one command at a time; the next command word is taken only once the
// result word of the last one has been accepted. The result word is offered
// once the scan token has left the last cell; the token walks the cell row one
// slot per cycle to find the oldest match. Slots past the count hold stale
// data and are never reported.
`default_nettype none
module unique_fifo_with_remove_and_find_core #(
   parameter int DEPTH = ufq_pkg::DEFAULT_DEPTH
) (
   input wire        clock,
   input wire        reset,
   ufq_req_if.sink   req_bus,
   ufq_rsp_if.source rsp_bus
);
   import ufq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   op_type              op;
   apply_type           apply;
   logic [CW-1:0]       count;
   // pass[i] feeds cell i; pass[DEPTH] comes out of the last cell
   pass_type            pass [DEPTH+1];
   logic [HANDLE_W-1:0] cell_handle [DEPTH];
   logic [ID_W-1:0]     cell_id [DEPTH];

   // sequencer: owns the handshakes, the count and the result registers
   ufq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .op          (op),
      .chain_start (pass[0]),
      .chain_end   (pass[DEPTH]),
      .apply       (apply),
      .count       (count)
   );

   // slot row; on removal each slot behind the hit copies its younger neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [HANDLE_W-1:0] nb_handle;
      logic [ID_W-1:0]     nb_id;

      if (i == DEPTH - 1) begin : g_tail
         // youngest slot has no neighbor; what it takes is past the count
         assign nb_handle = cell_handle[i];
         assign nb_id     = cell_id[i];
      end else begin : g_body
         assign nb_handle = cell_handle[i+1];
         assign nb_id     = cell_id[i+1];
      end

      ufq_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .apply       (apply),
         .count       (count),
         .pass_prev   (pass[i]),
         .pass_next   (pass[i+1]),
         .nb_handle   (nb_handle),
         .nb_id       (nb_id),
         .slot_handle (cell_handle[i]),
         .slot_id     (cell_id[i])
      );
   end

endmodule
`default_nettype wire
